// ===== sv/pdmt_pkg.sv =====
// shared constants and types of the pulse distance manchester transmitter
`default_nettype none

package pdmt_pkg;

   // default frame layout
   localparam int IdBitsDefault    = 14;
   localparam int TypeBitsDefault  = 4;
   localparam int ValueBitsDefault = 30;

   // timing and register widths
   localparam int DurBits     = 16;
   localparam int RepeatBits  = 8;
   localparam int CsrIdxBits  = 3;
   localparam int CsrDataBits = 32;

   // register indexes
   localparam logic [CsrIdxBits-1:0] CsrNodeId    = 3'd0;
   localparam logic [CsrIdxBits-1:0] CsrRepeat    = 3'd1;
   localparam logic [CsrIdxBits-1:0] CsrHighTicks = 3'd2;
   localparam logic [CsrIdxBits-1:0] CsrShortLow  = 3'd3;
   localparam logic [CsrIdxBits-1:0] CsrLongLow   = 3'd4;
   localparam logic [CsrIdxBits-1:0] CsrStopLow   = 3'd5;

   // register reset values
   localparam logic [DurBits-1:0] HighTicksReset = 16'd506;
   localparam logic [DurBits-1:0] ShortLowReset  = 16'd2024;
   localparam logic [DurBits-1:0] LongLowReset   = 16'd4301;
   localparam logic [DurBits-1:0] StopLowReset   = 16'd8602;

   // operation codes
   localparam logic OpStart = 1'b0;
   localparam logic OpTick  = 1'b1;

   typedef struct packed {
      logic [RepeatBits-1:0] repeat_count;
      logic [DurBits-1:0]    high_ticks;
      logic [DurBits-1:0]    short_low_ticks;
      logic [DurBits-1:0]    long_low_ticks;
      logic [DurBits-1:0]    stop_low_ticks;
   } timing_cfg_type;

endpackage

`default_nettype wire

// ===== sv/pdmt_if.sv =====
// channel interfaces of the pulse distance manchester transmitter
`default_nettype none

interface pdmt_req_if #(
   parameter int TYPE_BITS  = 4,
   parameter int VALUE_BITS = 30
);
   logic                  valid;
   logic                  ready;
   logic                  operation;
   logic [TYPE_BITS-1:0]  frame_type;
   logic [VALUE_BITS-1:0] value_magnitude;
   logic                  positive_flag;

   modport source (output valid, output operation, output frame_type,
                   output value_magnitude, output positive_flag, input ready);
   modport sink   (input valid, input operation, input frame_type,
                   input value_magnitude, input positive_flag, output ready);
endinterface

interface pdmt_rsp_if;
   logic valid;
   logic ready;
   logic pin_level;
   logic busy_res;
   logic start_rejected;
   logic burst_done;

   modport source (output valid, output pin_level, output busy_res,
                   output start_rejected, output burst_done, input ready);
   modport sink   (input valid, input pin_level, input busy_res,
                   input start_rejected, input burst_done, output ready);
endinterface

interface pdmt_csr_if #(
   parameter int IDX_BITS  = 3,
   parameter int DATA_BITS = 32
);
   logic                 valid;
   logic                 ready;
   logic [IDX_BITS-1:0]  index;
   logic [DATA_BITS-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/pdmt_csr.sv =====
// configuration registers of the pulse distance manchester transmitter
`default_nettype none

module pdmt_csr
   import pdmt_pkg::*;
#(
   parameter int ID_BITS = IdBitsDefault
) (
   input  wire logic               clock,
   input  wire logic               reset,
   pdmt_csr_if.sink                csr_ch,
   output      logic [ID_BITS-1:0] node_id,
   output      timing_cfg_type     timing_cfg
);

   logic [ID_BITS-1:0] node_id_ff;
   timing_cfg_type     cfg_ff;

   assign csr_ch.ready = 1'b1;
   assign node_id      = node_id_ff;
   assign timing_cfg   = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_id_ff             <= '0;
         cfg_ff.repeat_count    <= '0;
         cfg_ff.high_ticks      <= HighTicksReset;
         cfg_ff.short_low_ticks <= ShortLowReset;
         cfg_ff.long_low_ticks  <= LongLowReset;
         cfg_ff.stop_low_ticks  <= StopLowReset;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CsrNodeId:    node_id_ff <= csr_ch.data[ID_BITS-1:0];
            CsrRepeat:    cfg_ff.repeat_count <= csr_ch.data[RepeatBits-1:0];
            CsrHighTicks: cfg_ff.high_ticks <= csr_ch.data[DurBits-1:0];
            CsrShortLow:  cfg_ff.short_low_ticks <= csr_ch.data[DurBits-1:0];
            CsrLongLow:   cfg_ff.long_low_ticks <= csr_ch.data[DurBits-1:0];
            CsrStopLow:   cfg_ff.stop_low_ticks <= csr_ch.data[DurBits-1:0];
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== sv/pdmt_core.sv =====
// frame sequencer and result register of the pulse distance manchester transmitter
`default_nettype none

module pdmt_core
   import pdmt_pkg::*;
#(
   parameter int ID_BITS    = IdBitsDefault,
   parameter int TYPE_BITS  = TypeBitsDefault,
   parameter int VALUE_BITS = ValueBitsDefault
) (
   input  wire logic               clock,
   input  wire logic               reset,
   pdmt_req_if.sink                req_ch,
   pdmt_rsp_if.source              rsp_ch,
   input  wire logic [ID_BITS-1:0] node_id,
   input  wire timing_cfg_type     timing_cfg
);

   localparam int FrameLen   = ID_BITS + TYPE_BITS + 1 + VALUE_BITS;
   localparam int StopSymbol = 2 * FrameLen;
   localparam int SymBits    = $clog2(StopSymbol + 1);
   localparam logic [SymBits-1:0] StopIdx = SymBits'(StopSymbol);

   // burst state
   logic                  active_ff, active_in;
   logic [FrameLen-1:0]   frame_ff, frame_in;
   logic [RepeatBits-1:0] frames_left_ff, frames_left_in;
   logic [SymBits-1:0]    symbol_ff, symbol_in;
   logic                  low_ff, low_in;
   logic [DurBits-1:0]    tick_ff, tick_in;

   // result register
   logic rsp_valid_ff, rsp_valid_in;
   logic pin_ff, pin_in;
   logic busy_ff, busy_in;
   logic rej_ff, rej_in;
   logic done_ff, done_in;

   logic               accept;
   logic               at_stop;
   logic               sym_val;
   logic [DurBits-1:0] dur;
   logic [DurBits-1:0] tick_inc;
   logic               expire;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   // current bit sits at the top of the rotating frame register
   assign at_stop  = symbol_ff >= StopIdx;
   assign sym_val  = frame_ff[FrameLen-1] ^ symbol_ff[0];
   assign tick_inc = tick_ff + DurBits'(1);
   assign expire   = tick_inc >= dur;

   always_comb begin
      priority if (!low_ff) dur = timing_cfg.high_ticks;
      else if (at_stop)     dur = timing_cfg.stop_low_ticks;
      else if (sym_val)     dur = timing_cfg.short_low_ticks;
      else                  dur = timing_cfg.long_low_ticks;
   end

   always_comb begin
      active_in      = active_ff;
      frame_in       = frame_ff;
      frames_left_in = frames_left_ff;
      symbol_in      = symbol_ff;
      low_in         = low_ff;
      tick_in        = tick_ff;
      pin_in         = pin_ff;
      rej_in         = rej_ff;
      done_in        = done_ff;
      busy_in        = busy_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;

      if (accept) begin
         rsp_valid_in = 1'b1;
         pin_in       = 1'b0;
         rej_in       = 1'b0;
         done_in      = 1'b0;
         if (req_ch.operation == OpStart) begin
            if (active_ff) begin
               rej_in = 1'b1;
               pin_in = !low_ff;
            end else begin
               frame_in       = {node_id, req_ch.frame_type, req_ch.positive_flag,
                                 req_ch.value_magnitude};
               frames_left_in = timing_cfg.repeat_count;
               symbol_in      = '0;
               low_in         = 1'b0;
               tick_in        = '0;
               active_in      = 1'b1;
               pin_in         = 1'b1;
            end
         end else if (active_ff) begin
            pin_in  = !low_ff;
            tick_in = expire ? '0 : tick_inc;
            if (expire) begin
               if (!low_ff) begin
                  low_in = 1'b1;
               end else begin
                  low_in = 1'b0;
                  if (at_stop) begin
                     symbol_in = '0;
                     if (frames_left_ff == '0) begin
                        active_in = 1'b0;
                        done_in   = 1'b1;
                     end else begin
                        frames_left_in = frames_left_ff - RepeatBits'(1);
                     end
                  end else begin
                     symbol_in = symbol_ff + SymBits'(1);
                     // second half of a bit done: bring up the next bit
                     if (symbol_ff[0]) begin
                        frame_in = {frame_ff[FrameLen-2:0], frame_ff[FrameLen-1]};
                     end
                  end
               end
            end
         end
         busy_in = active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff      <= 1'b0;
         frames_left_ff <= '0;
         symbol_ff      <= '0;
         low_ff         <= 1'b0;
         tick_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         active_ff      <= active_in;
         frames_left_ff <= frames_left_in;
         symbol_ff      <= symbol_in;
         low_ff         <= low_in;
         tick_ff        <= tick_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
      pin_ff   <= pin_in;
      busy_ff  <= busy_in;
      rej_ff   <= rej_in;
      done_ff  <= done_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.pin_level      = pin_ff;
   assign rsp_ch.busy_res       = busy_ff;
   assign rsp_ch.start_rejected = rej_ff;
   assign rsp_ch.burst_done     = done_ff;

endmodule

`default_nettype wire

// ===== sv/pulse_distance_manchester_transmitter.sv =====
// top level of the pulse distance manchester transmitter
//
//   channel  dir  payload                                             transfer when
//   req_ch   in   operation, frame_type, value_magnitude, positive    valid && ready
//   rsp_ch   out  pin_level, busy_res, start_rejected, burst_done     valid && ready
//   csr_ch   in   index (register number), data                       valid && ready
//
// every request gives exactly one response, in the cycle after its transfer
// a new request is taken every cycle while no response stalls; the tick counter
// compare and frame bit select sit between burst state and response register
// req_ch.ready is low only while a response waits and rsp_ch.ready is low
// synchronous reset clears the burst state and loads the register defaults
// csr_ch is always ready; its writes take effect on the next cycle
`default_nettype none

module pulse_distance_manchester_transmitter
   import pdmt_pkg::*;
#(
   parameter int ID_BITS    = IdBitsDefault,
   parameter int TYPE_BITS  = TypeBitsDefault,
   parameter int VALUE_BITS = ValueBitsDefault
) (
   input wire logic   clock,
   input wire logic   reset,
   pdmt_req_if.sink   req_ch,
   pdmt_rsp_if.source rsp_ch,
   pdmt_csr_if.sink   csr_ch
);

   // live configuration; node id and repeat count are latched on an accepted start
   logic [ID_BITS-1:0] node_id;
   timing_cfg_type     timing_cfg;

   pdmt_csr #(
      .ID_BITS (ID_BITS)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_ch     (csr_ch),
      .node_id    (node_id),
      .timing_cfg (timing_cfg)
   );

   // sequencer: symbol index, high/low phase, tick counter, repeat count
   pdmt_core #(
      .ID_BITS    (ID_BITS),
      .TYPE_BITS  (TYPE_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .node_id    (node_id),
      .timing_cfg (timing_cfg)
   );

endmodule

`default_nettype wire

// ===== sv/pdmt_checker.sv =====
// port level checks of the pulse distance manchester transmitter
`default_nettype none

module pdmt_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic pin_level,
   input wire logic busy_res,
   input wire logic start_rejected,
   input wire logic burst_done
);

   // each request transfer shows a response on the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("no response after request transfer");

   // a waiting response holds until taken
   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(pin_level) && $stable(busy_res))
      else $error("response changed while stalled");

   // a finished burst leaves the block idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && burst_done |-> !busy_res && !start_rejected)
      else $error("burst done while still busy");

   // a rejected start only happens during a burst
   a_reject_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && start_rejected |-> busy_res)
      else $error("start rejected while idle");

   // the line stays low when idle
   a_idle_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !busy_res |-> !pin_level)
      else $error("line high while idle");

endmodule

bind pulse_distance_manchester_transmitter pdmt_checker u_pdmt_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .pin_level      (rsp_ch.pin_level),
   .busy_res       (rsp_ch.busy_res),
   .start_rejected (rsp_ch.start_rejected),
   .burst_done     (rsp_ch.burst_done)
);

`default_nettype wire

// ===== test/tb_pulse_distance_manchester_transmitter.sv =====
// self-checking testbench of the pulse distance manchester transmitter
module tb_pulse_distance_manchester_transmitter;
   import pdmt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // frame layout as seen on the line: node id, type, sign flag, magnitude
   localparam int FrameBits  = IdBitsDefault + TypeBitsDefault + 1 + ValueBitsDefault;
   localparam int StopSymbol = 2 * FrameBits;
   localparam logic [29:0] MagMax = 30'h3FFF_FFFF;

   // register indexes with no register behind them
   localparam logic [CsrIdxBits-1:0] CsrSpareLo = 3'd6;
   localparam logic [CsrIdxBits-1:0] CsrSpareHi = 3'd7;

   typedef struct packed {
      logic pin_level;
      logic busy_res;
      logic start_rejected;
      logic burst_done;
   } line_result_t;

   logic clock = 1'b0;
   logic reset;

   pdmt_req_if #(.TYPE_BITS(TypeBitsDefault), .VALUE_BITS(ValueBitsDefault)) req_ch ();
   pdmt_rsp_if rsp_ch ();
   pdmt_csr_if #(.IDX_BITS(CsrIdxBits), .DATA_BITS(CsrDataBits)) csr_ch ();

   pulse_distance_manchester_transmitter dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // register copies
   logic [IdBitsDefault-1:0] cfg_node_id;
   logic [RepeatBits-1:0]    cfg_repeat;
   logic [DurBits-1:0]       cfg_high;
   logic [DurBits-1:0]       cfg_short_low;
   logic [DurBits-1:0]       cfg_long_low;
   logic [DurBits-1:0]       cfg_stop_low;

   // burst state copies
   logic                  tx_active;
   logic [FrameBits-1:0]  tx_frame;   // msb is sent first
   logic [RepeatBits-1:0] tx_frames_left;
   logic [6:0]            tx_symbol;
   logic                  tx_low;
   logic [DurBits-1:0]    tx_ticks;

   line_result_t pending_lines[$];
   int fail_count;
   int rsp_seen;
   int send_idle_pct;
   int rsp_idle_pct;
   int hold_request;
   int hold_left;

   task automatic report_failure(string msg);
      if (fail_count < 40)
         $display("error at %0t: %s", $realtime, msg);
      fail_count++;
   endtask

   // register write as the block sees it: data beyond the field width is dropped
   function automatic void load_register(logic [CsrIdxBits-1:0] idx,
                                         logic [CsrDataBits-1:0] data);
      unique case (idx)
         CsrNodeId:    cfg_node_id   = data[IdBitsDefault-1:0];
         CsrRepeat:    cfg_repeat    = data[RepeatBits-1:0];
         CsrHighTicks: cfg_high      = data[DurBits-1:0];
         CsrShortLow:  cfg_short_low = data[DurBits-1:0];
         CsrLongLow:   cfg_long_low  = data[DurBits-1:0];
         CsrStopLow:   cfg_stop_low  = data[DurBits-1:0];
         default: ;
      endcase
   endfunction

   // one item of the encoder: updates the burst state, returns the line levels
   function automatic line_result_t line_step(logic op, logic [TypeBitsDefault-1:0] ftype,
                                              logic [ValueBitsDefault-1:0] mag, logic pos);
      line_result_t r;
      logic [DurBits-1:0] dur;
      logic sym;
      int bit_pos;
      r = '0;
      if (op == OpStart) begin
         if (tx_active) begin
            r.start_rejected = 1'b1;
         end else begin
            tx_frame       = {cfg_node_id, ftype, pos, mag};
            tx_frames_left = cfg_repeat;
            tx_symbol      = '0;
            tx_low         = 1'b0;
            tx_ticks       = '0;
            tx_active      = 1'b1;
         end
         r.pin_level = tx_active && !tx_low;
      end else if (tx_active) begin
         r.pin_level = !tx_low;
         if (!tx_low) begin
            dur = cfg_high;
         end else if (tx_symbol >= StopSymbol) begin
            dur = cfg_stop_low;
         end else begin
            // a frame bit goes out as itself, then as its complement
            bit_pos = FrameBits - 1 - int'(tx_symbol[6:1]);
            sym = tx_frame[bit_pos] ^ tx_symbol[0];
            dur = sym ? cfg_short_low : cfg_long_low;
         end
         tx_ticks = tx_ticks + 1'b1;
         // a zero duration behaves as one tick
         if (tx_ticks >= dur) begin
            tx_ticks = '0;
            if (!tx_low) begin
               tx_low = 1'b1;
            end else begin
               tx_low = 1'b0;
               if (tx_symbol >= StopSymbol) begin
                  tx_symbol = '0;
                  if (tx_frames_left == 0) begin
                     tx_active = 1'b0;
                     r.burst_done = 1'b1;
                  end else begin
                     tx_frames_left = tx_frames_left - 1'b1;
                  end
               end else begin
                  tx_symbol = tx_symbol + 1'b1;
               end
            end
         end
      end
      r.busy_res = tx_active;
      return r;
   endfunction

   // one transfer on the request channel, with random gaps in front of it
   task automatic send_item(logic op, logic [TypeBitsDefault-1:0] ftype,
                            logic [ValueBitsDefault-1:0] mag, logic pos);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid           = 1'b1;
      req_ch.operation       = op;
      req_ch.frame_type      = ftype;
      req_ch.value_magnitude = mag;
      req_ch.positive_flag   = pos;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_lines.push_back(line_step(op, ftype, mag, pos));
   endtask

   // payload on a tick is random: the block must ignore it
   task automatic send_tick();
      send_item(OpTick, 4'($urandom_range(0, 15)), 30'($urandom_range(0, MagMax)),
                1'($urandom_range(0, 1)));
   endtask

   task automatic send_random_start();
      send_item(OpStart, 4'($urandom_range(0, 15)), 30'($urandom_range(0, MagMax)),
                1'($urandom_range(0, 1)));
   endtask

   // ticks until the burst ends, with a few starts thrown in that must bounce
   task automatic run_out_burst(int noise_pct);
      while (tx_active) begin
         if ($urandom_range(99) < noise_pct)
            send_random_start();
         else
            send_tick();
      end
   endtask

   // sender stops and lets every response come back
   task automatic wait_all_results();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending_lines.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_csr(logic [CsrIdxBits-1:0] idx, logic [CsrDataBits-1:0] data);
      @(negedge clock);
      csr_ch.valid = 1'b1;
      csr_ch.index = idx;
      csr_ch.data  = data;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      load_register(idx, data);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   task automatic set_timing(logic [31:0] high, logic [31:0] short_low,
                             logic [31:0] long_low, logic [31:0] stop_low);
      write_csr(CsrHighTicks, high);
      write_csr(CsrShortLow, short_low);
      write_csr(CsrLongLow, long_low);
      write_csr(CsrStopLow, stop_low);
   endtask

   // duration with junk in the upper data bits
   function automatic logic [31:0] junk_high(logic [DurBits-1:0] ticks);
      return ($urandom & 32'hFFFF_0000) | {16'h0000, ticks};
   endfunction

   // idle line after reset, writes to indexes with no register
   task automatic test_idle_after_reset();
      repeat (3) send_tick();
      wait_all_results();
      write_csr(CsrSpareLo, 32'hFFFF_FFFF);
      write_csr(CsrSpareHi, 32'hFFFF_FFFF);
      repeat (2) send_tick();
   endtask

   // two frames of random contents; zero high time acts as one tick,
   // one of the two low times is longer so the symbol value shows
   task automatic test_start_burst();
      logic short_longer;
      wait_all_results();
      write_csr(CsrNodeId, $urandom);
      write_csr(CsrRepeat, ($urandom & 32'hFFFF_FF00) | 32'h0000_0001);
      short_longer = 1'($urandom_range(1));
      set_timing(junk_high(16'd0), junk_high(short_longer ? 16'd2 : 16'd1),
                 junk_high(short_longer ? 16'd1 : 16'd2), junk_high(16'd3));
      send_random_start();
      // a second start while the first is running must bounce
      send_random_start();
   endtask

   // ticks mixed with starts that must bounce
   task automatic test_bounced_starts(int count);
      repeat (count) begin
         if ($urandom_range(99) < 5)
            send_random_start();
         else
            send_tick();
      end
   endtask

   // response side stalls for a long stretch while ticks keep coming
   task automatic test_receiver_backpressure();
      hold_request = 150;
      repeat (30) send_tick();
   endtask

   // request side goes quiet mid burst until the line of responses is empty
   task automatic test_sender_pause();
      repeat (20) send_tick();
      wait_all_results();
      repeat (10) send_tick();
   endtask

   // second frame, burst done, then an idle line again
   task automatic test_burst_finish();
      run_out_burst(3);
      repeat (3) send_tick();
   endtask

   // response ready, with long holds counted here
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready = 1'b0;
      end else begin
         rsp_ch.ready = ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // each response transfer against the oldest expectation
   always @(posedge clock) begin
      line_result_t want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
         rsp_seen++;
         if (pending_lines.size() == 0) begin
            report_failure($sformatf("response %0d with nothing pending", rsp_seen));
         end else begin
            want = pending_lines.pop_front();
            if (rsp_ch.pin_level !== want.pin_level)
               report_failure($sformatf("response %0d pin_level %b, want %b",
                                        rsp_seen, rsp_ch.pin_level, want.pin_level));
            if (rsp_ch.busy_res !== want.busy_res)
               report_failure($sformatf("response %0d busy_res %b, want %b",
                                        rsp_seen, rsp_ch.busy_res, want.busy_res));
            if (rsp_ch.start_rejected !== want.start_rejected)
               report_failure($sformatf("response %0d start_rejected %b, want %b",
                                        rsp_seen, rsp_ch.start_rejected,
                                        want.start_rejected));
            if (rsp_ch.burst_done !== want.burst_done)
               report_failure($sformatf("response %0d burst_done %b, want %b",
                                        rsp_seen, rsp_ch.burst_done, want.burst_done));
         end
      end
   end

   initial begin
      // known levels on every input from time zero
      reset                  = 1'b1;
      req_ch.valid           = 1'b0;
      req_ch.operation       = OpTick;
      req_ch.frame_type      = '0;
      req_ch.value_magnitude = '0;
      req_ch.positive_flag   = 1'b0;
      rsp_ch.ready           = 1'b0;
      csr_ch.valid           = 1'b0;
      csr_ch.index           = CsrNodeId;
      csr_ch.data            = '0;
      hold_request = 0;
      hold_left    = 0;
      fail_count   = 0;
      rsp_seen     = 0;

      // register defaults and an idle encoder
      cfg_node_id    = '0;
      cfg_repeat     = '0;
      cfg_high       = HighTicksReset;
      cfg_short_low  = ShortLowReset;
      cfg_long_low   = LongLowReset;
      cfg_stop_low   = StopLowReset;
      tx_active      = 1'b0;
      tx_frame       = '0;
      tx_frames_left = '0;
      tx_symbol      = '0;
      tx_low         = 1'b0;
      tx_ticks       = '0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // slow response side
      send_idle_pct = 14;
      rsp_idle_pct  = 71;
      test_idle_after_reset();
      test_start_burst();
      test_bounced_starts(150);

      // slow request side
      send_idle_pct = 71;
      rsp_idle_pct  = 14;
      test_receiver_backpressure();
      test_sender_pause();

      // full rate
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      test_burst_finish();

      wait_all_results();
      repeat (4) @(posedge clock);
      if (fail_count == 0 && pending_lines.size() == 0) begin
         $display("PASS pulse_distance_manchester_transmitter");
      end else begin
         $display("FAIL pulse_distance_manchester_transmitter");
      end
      $finish;
   end

   // hang guard, far beyond the slowest correct run
   initial begin
      #100_000;
      $display("FAIL pulse_distance_manchester_transmitter");
      $finish;
   end

endmodule
